// ----- rtl/pbs_pkg.sv -----
// Shared types and codes for the power button supervisor.
package pbs_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned DurWidth  = 16;

  // Operation codes carried in tuser
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_ON        = 3'd1;
  localparam logic [2:0] OP_OFF       = 3'd2;
  localparam logic [2:0] OP_DONTCARE  = 3'd3;
  localparam logic [2:0] OP_FORCE_OFF = 3'd4;
  localparam logic [2:0] OP_RESET     = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRESS_DURATION     = 2'd0;
  localparam logic [1:0] CFG_FORCE_OFF_DURATION = 2'd1;
  localparam logic [1:0] CFG_CHECK_INTERVAL     = 2'd2;

  typedef enum logic [1:0] {
    MODE_DONTCARE = 2'd0,
    MODE_ON       = 2'd1,
    MODE_OFF      = 2'd2
  } mode_t;

  typedef struct packed {
    logic [DurWidth-1:0] press_duration;
    logic [DurWidth-1:0] force_off_duration;
    logic [DurWidth-1:0] check_interval;
  } cfg_t;

  typedef struct packed {
    logic [TimeWidth-1:0] clock_ms;
    mode_t                target_mode;
    logic [TimeWidth-1:0] power_deadline;
    logic [TimeWidth-1:0] reset_deadline;
    logic [TimeWidth-1:0] check_due;
    logic                 power_line_low;
    logic                 reset_line_low;
  } sup_state_t;

endpackage

// ----- rtl/pbs_step.sv -----
// Next-state logic of the supervisor for one tick or command.
module pbs_step (
  input  pbs_pkg::sup_state_t st,
  input  pbs_pkg::cfg_t       cfg,
  input  logic [2:0]          op,
  input  logic                sense,
  output pbs_pkg::sup_state_t st_next
);
  import pbs_pkg::*;

  logic [TimeWidth-1:0] clk_inc;
  logic [TimeWidth-1:0] press_ext;
  logic [TimeWidth-1:0] force_ext;
  logic [TimeWidth-1:0] interval_ext;
  logic                 want_on;

  assign clk_inc      = st.clock_ms + TimeWidth'(1);
  assign press_ext    = TimeWidth'(cfg.press_duration);
  assign force_ext    = TimeWidth'(cfg.force_off_duration);
  assign interval_ext = TimeWidth'(cfg.check_interval);
  assign want_on      = (st.target_mode == MODE_ON);

  always_comb begin
    st_next = st;
    unique case (op)
      OP_TICK: begin
        st_next.clock_ms = clk_inc;
        if (st.power_deadline != '0 && clk_inc > st.power_deadline) begin
          st_next.power_line_low = 1'b0;
          st_next.power_deadline = '0;
        end
        if (st.reset_deadline != '0 && clk_inc > st.reset_deadline) begin
          st_next.reset_line_low = 1'b0;
          st_next.reset_deadline = '0;
        end
        if (st.target_mode != MODE_DONTCARE && st.check_due < clk_inc) begin
          // The released deadline, if any, counts as idle for this check.
          if (sense != want_on && st_next.power_deadline == '0) begin
            st_next.power_line_low = 1'b1;
            st_next.power_deadline = clk_inc + press_ext;
          end
          st_next.check_due = clk_inc + interval_ext;
        end
      end
      OP_ON: begin
        if (st.target_mode != MODE_ON) begin
          st_next.target_mode = MODE_ON;
          st_next.check_due   = '0;
        end
      end
      OP_OFF: begin
        if (st.target_mode != MODE_OFF) begin
          st_next.target_mode = MODE_OFF;
          st_next.check_due   = '0;
        end
      end
      OP_DONTCARE: begin
        st_next.target_mode = MODE_DONTCARE;
      end
      OP_FORCE_OFF: begin
        st_next.target_mode = MODE_OFF;
        if (sense) begin
          st_next.power_line_low = 1'b1;
          st_next.power_deadline = st.clock_ms + force_ext;
        end
      end
      OP_RESET: begin
        if (st.target_mode != MODE_DONTCARE) begin
          st_next.target_mode = MODE_ON;
          st_next.check_due   = '0;
        end
        if (sense) begin
          st_next.reset_line_low = 1'b1;
          st_next.reset_deadline = st.clock_ms + press_ext;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

endmodule

// ----- rtl/power_button_supervisor.sv -----
// Top level of the power button supervisor: stream ports, registers and state.
// Each accepted transaction is held in the input register, then moves into the
// result register, which drives m_tvalid.
// Throughput: one transaction per cycle while m_tready keeps the result
// register draining; the single state update per item, made as the item
// leaves the input register, sets that rate.
// Reset (rst, synchronous, active high) empties both registers, clears the
// supervisor state and loads the configuration defaults 500, 5000 and 10000.
module power_button_supervisor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] power_sense, [7:1] zero
  input  logic [2:0]  s_tuser,   // [2:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] power_pull, [1] reset_pull, [3:2] mode_now, [7:4] zero
);
  import pbs_pkg::*;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  cfg_t cfg;

  // Input register: holds one accepted transaction until it is processed.
  logic       in_valid;
  logic [2:0] in_op;
  logic       in_sense;

  // Supervisor state; it is updated exactly once per item, in item order.
  sup_state_t st;
  sup_state_t st_next;

  // Result register.
  logic  out_valid;
  logic  out_power;
  logic  out_reset;
  mode_t out_mode;

  logic advance;

  // The result register can take a new item when it is empty or being drained;
  // the input register refills in the same cycle, so back-to-back items flow.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  pbs_step u_step (
    .st      (st),
    .cfg     (cfg),
    .op      (in_op),
    .sense   (in_sense),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_duration     <= 16'd500;
      cfg.force_off_duration <= 16'd5000;
      cfg.check_interval     <= 16'd10000;
      in_valid               <= 1'b0;
      out_valid              <= 1'b0;
      st                     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PRESS_DURATION:     cfg.press_duration     <= cfg_data;
          CFG_FORCE_OFF_DURATION: cfg.force_off_duration <= cfg_data;
          CFG_CHECK_INTERVAL:     cfg.check_interval     <= cfg_data;
          default: begin
            // Writes beyond the register list are dropped.
          end
        endcase
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
        if (in_valid) begin
          st <= st_next;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op    <= s_tuser;
      in_sense <= s_tdata[0];
    end
    if (advance && in_valid) begin
      out_power <= st_next.power_line_low;
      out_reset <= st_next.reset_line_low;
      out_mode  <= st_next.target_mode;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_mode, out_reset, out_power};

endmodule

// ----- rtl/pbs_checker.sv -----
// Port-level checker for the power button supervisor, bound to the top level.
module pbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // The target mode is never the unused code and padding stays zero.
  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:2] != 2'b11 && m_tdata[7:4] == 4'b0000))
    else $error("bad mode code or padding in result");

  // With the result stalled, one more item fills the input register, after
  // which the input side follows the output side's ready.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && s_tvalid && s_tready) |=> (s_tready == m_tready))
    else $error("input ready ignores stalled result");

endmodule

bind power_button_supervisor pbs_checker u_pbs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
